// ===== rtl/kbh_pkg.sv =====
`default_nettype none
package kbh_pkg;

  // event codes carried in the input selector
  typedef enum logic [3:0] {
    FN_REPORT  = 4'd0,
    FN_TOGGLE  = 4'd1,
    FN_DOWN    = 4'd2,
    FN_UP      = 4'd3,
    FN_CYCLE   = 4'd4,
    FN_LOCK    = 4'd5,
    FN_SET_LVL = 4'd6,
    FN_SET_RGB = 4'd7,
    FN_INIT    = 4'd8
  } func_t;

  typedef logic [7:0]  level_t;
  typedef logic [23:0] rgb_t;

  localparam int NUM_LEVELS = 6;
  localparam int NUM_COLORS = 7;

  // configuration register indexes
  localparam logic REG_COLOR_MODE = 1'b0;

  localparam level_t LVL_TABLE [NUM_LEVELS] = '{
    8'd48, 8'd72, 8'd96, 8'd144, 8'd192, 8'd255
  };

  localparam rgb_t RGB_TABLE [NUM_COLORS] = '{
    24'hFFFFFF, 24'h0000FF, 24'hFF0000, 24'hFF00FF, 24'h00FF00, 24'h00FFFF, 24'hFFFF00
  };

  localparam rgb_t   RGB_WHITE  = 24'hFFFFFF;
  localparam level_t SAVED_INIT = 8'd72;
  localparam level_t LEVEL_MAX  = 8'd255;

  // clamp a 24-bit brightness to eight bits
  function automatic level_t sat_level(input rgb_t v);
    sat_level = (v[23:8] != 16'd0) ? LEVEL_MAX : v[7:0];
  endfunction

  // highest table level below lvl; found is low when there is none
  function automatic logic [8:0] step_down(input level_t lvl);
    logic   found;
    level_t nxt;
    found = 1'b0;
    nxt   = '0;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      if (LVL_TABLE[i] < lvl) begin
        found = 1'b1;
        nxt   = LVL_TABLE[i];
      end
    end
    step_down = {found, nxt};
  endfunction

  // lowest table level above lvl; found is low when there is none
  function automatic logic [8:0] step_up(input level_t lvl);
    logic   found;
    level_t nxt;
    found = 1'b0;
    nxt   = '0;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (LVL_TABLE[i] > lvl) begin
        found = 1'b1;
        nxt   = LVL_TABLE[i];
      end
    end
    step_up = {found, nxt};
  endfunction

  // next colour in the cycle, an unknown colour wraps to white
  function automatic rgb_t next_color(input rgb_t cur);
    rgb_t nxt;
    nxt = RGB_WHITE;
    for (int i = 0; i < NUM_COLORS - 1; i++) begin
      if (RGB_TABLE[i] == cur) begin
        nxt = RGB_TABLE[i + 1];
      end
    end
    next_color = nxt;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/keyboard_backlight_hotkey_ctrl_unit.sv =====
// an event passes through the input register and then the result register before its result is valid
// throughput: one event per cycle while the output is not stalled; the event logic sits between the two registers
// an input transfer is still taken while one finished result waits on the output
// reset: synchronous, active low; clears brightness, saved level, colour, colour valid,
// colour mode and both valid flags
`default_nettype none
module keyboard_backlight_hotkey_ctrl_unit
  import kbh_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // event channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // value[23:0]
  input  wire logic [3:0]  in_tuser,   // func[3:0]
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // level_write[0], level_value[8:1], color_write[9], color_value[33:10],
  // notify_change[34], current_level[42:35], lock_pulse[43], zero[47:44]
  output logic [47:0]      out_tdata,
  // configuration port
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  logic        in_valid_r;
  logic [3:0]  in_func_r;
  rgb_t        in_value_r;
  logic        out_valid_r;
  logic [47:0] out_data_r;
  logic [47:0] out_data_nxt;

  level_t level_now_r,   level_now_nxt;
  level_t level_saved_r, level_saved_nxt;
  rgb_t   color_now_r,   color_now_nxt;
  logic   color_valid_r, color_valid_nxt;
  logic   color_mode_r;

  logic   advance;
  logic   in_xfer;
  logic   cfg_wr;

  // handshake control
  assign advance    = !out_valid_r || out_tready;
  assign in_tready  = !in_valid_r || advance;
  assign in_xfer    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_COLOR_MODE) ? {31'd0, color_mode_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_mode_r <= 1'b0;
    end else if (cfg_wr && cfg_paddr[2] == REG_COLOR_MODE) begin
      color_mode_r <= cfg_pwdata[0];
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_xfer) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_func_r  <= in_tuser;
      in_value_r <= in_tdata;
    end
  end

  // event logic
  always_comb begin
    logic       lw, cw, nt, lk;
    level_t     lv;
    rgb_t       cv;
    logic [8:0] stp;
    lw  = 1'b0;
    cw  = 1'b0;
    nt  = 1'b0;
    lk  = 1'b0;
    lv  = '0;
    cv  = '0;
    stp = '0;
    level_now_nxt   = level_now_r;
    level_saved_nxt = level_saved_r;
    color_now_nxt   = color_now_r;
    color_valid_nxt = color_valid_r;
    case (func_t'(in_func_r))
      FN_REPORT: begin
        level_now_nxt = sat_level(in_value_r);
        nt = 1'b1;
      end
      FN_TOGGLE: begin
        lw = 1'b1;
        nt = 1'b1;
        if (level_now_r != 8'd0) begin
          level_saved_nxt = level_now_r;
          level_now_nxt   = 8'd0;
        end else begin
          level_now_nxt = level_saved_r;
          lv            = level_saved_r;
        end
      end
      FN_DOWN, FN_UP: begin
        nt = 1'b1;
        if (level_now_r != 8'd0) begin
          stp = (func_t'(in_func_r) == FN_DOWN) ? step_down(level_now_r) : step_up(level_now_r);
          if (stp[8]) begin
            lw            = 1'b1;
            lv            = stp[7:0];
            level_now_nxt = stp[7:0];
          end
        end else begin
          lw            = 1'b1;
          lv            = level_saved_r;
          level_now_nxt = level_saved_r;
        end
      end
      FN_CYCLE: begin
        if (color_valid_r) begin
          nt = 1'b1;
          if (level_now_r != 8'd0) begin
            color_now_nxt = next_color(color_now_r);
            cw            = 1'b1;
            cv            = color_now_nxt;
          end else begin
            lw            = 1'b1;
            lv            = level_saved_r;
            level_now_nxt = level_saved_r;
          end
        end
      end
      FN_LOCK: begin
        lk = 1'b1;
      end
      FN_SET_LVL: begin
        lw            = 1'b1;
        lv            = sat_level(in_value_r);
        level_now_nxt = lv;
      end
      FN_SET_RGB: begin
        if (color_valid_r) begin
          color_now_nxt = in_value_r;
          cw            = 1'b1;
          cv            = in_value_r;
        end
      end
      FN_INIT: begin
        level_now_nxt   = 8'd0;
        color_valid_nxt = color_mode_r;
        if (color_mode_r) begin
          level_saved_nxt = SAVED_INIT;
          color_now_nxt   = RGB_WHITE;
          cw              = 1'b1;
          cv              = RGB_WHITE;
        end else begin
          level_saved_nxt = 8'd0;
          color_now_nxt   = '0;
        end
      end
      default: begin
      end
    endcase
    out_data_nxt = {4'd0, lk, level_now_nxt, nt, cv, cw, lv, lw};
  end

  // held state, updated as an event moves into the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_now_r   <= '0;
      level_saved_r <= '0;
      color_now_r   <= '0;
      color_valid_r <= 1'b0;
    end else if (advance && in_valid_r) begin
      level_now_r   <= level_now_nxt;
      level_saved_r <= level_saved_nxt;
      color_now_r   <= color_now_nxt;
      color_valid_r <= color_valid_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid_r) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/kbh_checker.sv =====
`default_nettype none
module kbh_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [47:0] out_tdata
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // nothing is shown in the cycle after reset
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // with the output empty the input side is always open
  assert property (@(posedge clk) disable iff (!rst_n) !out_tvalid |-> in_tready)
    else $error("input stalled while output empty");

  // a written value is zero unless its write flag is set
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[0] || out_tdata[8:1] == 8'd0)
                && (out_tdata[9] || out_tdata[33:10] == 24'd0))
    else $error("value present without write flag");

  // a lock key result carries no write and no notify
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[43] |-> !out_tdata[0] && !out_tdata[9] && !out_tdata[34])
    else $error("lock pulse mixed with other actions");

endmodule

bind keyboard_backlight_hotkey_ctrl_unit kbh_checker u_kbh_checker (.*);
`default_nettype wire

// ===== tb/keyboard_backlight_hotkey_ctrl_unit_test.sv =====
`timescale 1ns / 100ps
module keyboard_backlight_hotkey_ctrl_unit_test;
  import kbh_pkg::*;

  // result fields as packed on out_tdata, top bits first
  typedef struct packed {
    logic [3:0] pad;
    logic       lock;
    level_t     cur;
    logic       notify;
    rgb_t       rgb_val;
    logic       rgb_wr;
    level_t     lvl_val;
    logic       lvl_wr;
  } kbl_result_t;

  // one line of the directed script
  typedef struct packed {
    logic        mode;
    logic [3:0]  fn;
    rgb_t        val;
    logic        typed;
    kbl_result_t want;
  } step_row_t;

  // event codes outside the package list
  localparam logic [3:0] FN_NONE_LO = 4'd9;
  localparam logic [3:0] FN_NONE_HI = 4'd15;
  localparam logic [2:0] MODE_ADDR  = {REG_COLOR_MODE, 2'b00};
  localparam int N_DIRECTED = 25;
  localparam int N_PHASES   = 6;
  localparam int PHASE_ITEMS = 275;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic [3:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // shadow of the block state
  level_t lamp_level = '0;
  level_t lamp_saved = '0;
  rgb_t   key_rgb = '0;
  logic   rgb_enabled = 1'b0;
  logic   rgb_mode = 1'b0;

  kbl_result_t pending_results[$];
  logic steady_run = 1'b0;
  int error_count = 0;
  int events_sent = 0;
  int results_seen = 0;
  int rgb_writes_seen = 0;
  int lock_pulses_seen = 0;
  int mode_writes = 0;

  keyboard_backlight_hotkey_ctrl_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // hard stop if the run hangs
  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  // backlight behaviour for one event, updates the shadow state
  function automatic kbl_result_t apply_event(input logic [3:0] fn, input rgb_t val);
    kbl_result_t r;
    level_t      clamp;
    rgb_t        nxt;
    logic        hit;
    int          k;
    r = '0;
    hit = 1'b0;
    clamp = (val > 24'd255) ? 8'd255 : val[7:0];
    case (fn)
      FN_REPORT: begin
        lamp_level = clamp;
        r.notify = 1'b1;
      end
      FN_TOGGLE: begin
        if (lamp_level != 8'd0) begin
          lamp_saved = lamp_level;
          lamp_level = 8'd0;
        end else begin
          lamp_level = lamp_saved;
        end
        r.lvl_wr = 1'b1;
        r.lvl_val = lamp_level;
        r.notify = 1'b1;
      end
      FN_DOWN, FN_UP: begin
        if (lamp_level == 8'd0) begin
          lamp_level = lamp_saved;
          r.lvl_wr = 1'b1;
          r.lvl_val = lamp_level;
        end else if (fn == FN_DOWN) begin
          for (k = NUM_LEVELS - 1; k >= 0; k--) begin
            if (!hit && LVL_TABLE[k] < lamp_level) begin
              hit = 1'b1;
              lamp_level = LVL_TABLE[k];
              r.lvl_wr = 1'b1;
              r.lvl_val = lamp_level;
            end
          end
        end else begin
          for (k = 0; k < NUM_LEVELS; k++) begin
            if (!hit && LVL_TABLE[k] > lamp_level) begin
              hit = 1'b1;
              lamp_level = LVL_TABLE[k];
              r.lvl_wr = 1'b1;
              r.lvl_val = lamp_level;
            end
          end
        end
        r.notify = 1'b1;
      end
      FN_CYCLE: begin
        if (rgb_enabled) begin
          if (lamp_level != 8'd0) begin
            // unknown colours fall back to white
            nxt = RGB_WHITE;
            for (k = 0; k < NUM_COLORS; k++) begin
              if (RGB_TABLE[k] == key_rgb) nxt = RGB_TABLE[(k + 1) % NUM_COLORS];
            end
            key_rgb = nxt;
            r.rgb_wr = 1'b1;
            r.rgb_val = key_rgb;
          end else begin
            lamp_level = lamp_saved;
            r.lvl_wr = 1'b1;
            r.lvl_val = lamp_level;
          end
          r.notify = 1'b1;
        end
      end
      FN_LOCK: begin
        r.lock = 1'b1;
      end
      FN_SET_LVL: begin
        lamp_level = clamp;
        r.lvl_wr = 1'b1;
        r.lvl_val = clamp;
      end
      FN_SET_RGB: begin
        if (rgb_enabled) begin
          key_rgb = val;
          r.rgb_wr = 1'b1;
          r.rgb_val = val;
        end
      end
      FN_INIT: begin
        lamp_level = 8'd0;
        rgb_enabled = rgb_mode;
        if (rgb_mode) begin
          lamp_saved = SAVED_INIT;
          key_rgb = RGB_WHITE;
          r.rgb_wr = 1'b1;
          r.rgb_val = RGB_WHITE;
        end else begin
          lamp_saved = 8'd0;
          key_rgb = '0;
        end
      end
      default: begin
      end
    endcase
    r.cur = lamp_level;
    return r;
  endfunction

  function automatic kbl_result_t res(input logic lw, input level_t lv, input logic cw,
                                      input rgb_t cv, input logic nt, input level_t cur,
                                      input logic lk);
    kbl_result_t r;
    r = '0;
    r.lvl_wr = lw;
    r.lvl_val = lv;
    r.rgb_wr = cw;
    r.rgb_val = cv;
    r.notify = nt;
    r.cur = cur;
    r.lock = lk;
    return r;
  endfunction

  function automatic step_row_t mk_row(input logic mode, input logic [3:0] fn, input rgb_t val,
                                       input logic typed, input kbl_result_t want);
    step_row_t r;
    r.mode = mode;
    r.fn = fn;
    r.val = val;
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  // directed script: colour mode, event, value, and a written-out result where obvious
  function automatic step_row_t directed_row(input int k);
    kbl_result_t none;
    none = '0;
    case (k)
      0:  return mk_row(1'b0, FN_NONE_LO, 24'h000000, 1'b1, res(0, 0, 0, 0, 0, 0, 0));
      1:  return mk_row(1'b0, FN_REPORT, 24'hFFFFFF, 1'b1, res(0, 0, 0, 0, 1, 255, 0));
      2:  return mk_row(1'b0, FN_UP, 24'h000000, 1'b1, res(0, 0, 0, 0, 1, 255, 0));
      3:  return mk_row(1'b0, FN_REPORT, 24'h000000, 1'b1, res(0, 0, 0, 0, 1, 0, 0));
      4:  return mk_row(1'b0, FN_TOGGLE, 24'h000000, 1'b1, res(1, 0, 0, 0, 1, 0, 0));
      5:  return mk_row(1'b0, FN_SET_LVL, 24'h000100, 1'b1, res(1, 255, 0, 0, 0, 255, 0));
      6:  return mk_row(1'b0, FN_TOGGLE, 24'hABCDEF, 1'b0, none);
      7:  return mk_row(1'b0, FN_UP, 24'h000000, 1'b0, none);
      8:  return mk_row(1'b0, FN_REPORT, 24'h000028, 1'b0, none);
      // below the lowest table level: no step, still notifies
      9:  return mk_row(1'b0, FN_DOWN, 24'h000000, 1'b0, none);
      10: return mk_row(1'b0, FN_CYCLE, 24'hFFFFFF, 1'b1, res(0, 0, 0, 0, 0, 40, 0));
      11: return mk_row(1'b0, FN_SET_RGB, 24'h123456, 1'b1, res(0, 0, 0, 0, 0, 40, 0));
      12: return mk_row(1'b0, FN_LOCK, 24'h000000, 1'b1, res(0, 0, 0, 0, 0, 40, 1));
      13: return mk_row(1'b0, FN_NONE_HI, 24'hFFFFFF, 1'b1, res(0, 0, 0, 0, 0, 40, 0));
      14: return mk_row(1'b1, FN_INIT, 24'hFFFFFF, 1'b1, res(0, 0, 1, 24'hFFFFFF, 0, 0, 0));
      // colour cycle at zero brings the saved level back
      15: return mk_row(1'b1, FN_CYCLE, 24'h000000, 1'b0, none);
      16: return mk_row(1'b1, FN_CYCLE, 24'h000000, 1'b0, none);
      17: return mk_row(1'b1, FN_SET_RGB, 24'h123456, 1'b0, none);
      18: return mk_row(1'b1, FN_CYCLE, 24'h000000, 1'b0, none);
      19: return mk_row(1'b1, FN_SET_RGB, 24'hFFFF00, 1'b0, none);
      20: return mk_row(1'b1, FN_CYCLE, 24'h000000, 1'b0, none);
      21: return mk_row(1'b1, FN_DOWN, 24'h000000, 1'b0, none);
      22: return mk_row(1'b1, FN_SET_LVL, 24'h000000, 1'b0, none);
      23: return mk_row(1'b1, FN_DOWN, 24'h000000, 1'b0, none);
      default: return mk_row(1'b0, FN_INIT, 24'h000000, 1'b1, res(0, 0, 0, 0, 0, 0, 0));
    endcase
  endfunction

  // brightness values near the table steps, at the ends and beyond eight bits
  function automatic rgb_t pick_level_value();
    case ($urandom_range(0, 4))
      0: return 24'd0;
      1: return 24'(int'(LVL_TABLE[$urandom_range(0, NUM_LEVELS - 1)]) + $urandom_range(0, 2) - 1);
      2: return 24'($urandom_range(0, 255));
      3: return 24'($urandom_range(0, 24'hFFFFFF));
      default: return 24'd255;
    endcase
  endfunction

  function automatic rgb_t pick_rgb_value();
    if ($urandom_range(0, 3) != 0) return RGB_TABLE[$urandom_range(0, NUM_COLORS - 1)];
    return 24'($urandom_range(0, 24'hFFFFFF));
  endfunction

  // one event transfer; valid stays up when the next event follows straight on
  task automatic send_event(input logic [3:0] fn, input rgb_t val, input logic typed,
                            input kbl_result_t want);
    kbl_result_t predicted;
    if (!steady_run) begin
      while ($urandom_range(0, 99) < 9) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tuser <= fn;
    in_tdata <= val;
    do @(posedge clk); while (!in_tready);
    predicted = apply_event(fn, val);
    pending_results.push_back(typed ? want : predicted);
    events_sent++;
  endtask

  // stop sending and wait for every outstanding result
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_mode(input logic mode);
    logic [31:0] wdata;
    wdata = $urandom();
    wdata[0] = mode;
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= MODE_ADDR;
    cfg_pwdata <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rgb_mode = mode;
    mode_writes++;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // result sink with random stalls, always ready during the steady phase
  always @(posedge clk) begin
    if (steady_run) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= 9);
    end
  end

  task automatic check_field(input string name, input logic [23:0] want, input logic [23:0] got);
    if (want !== got) begin
      if (error_count < 10) begin
        $display("mismatch on result %0d, %s: expected 0x%0h, got 0x%0h",
                 results_seen, name, want, got);
      end
      error_count++;
    end
  endtask

  // compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    kbl_result_t got;
    kbl_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (pending_results.size() == 0) begin
        if (error_count < 10) $display("result 0x%0h arrived with none outstanding", out_tdata);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("level_write", 24'(want.lvl_wr), 24'(got.lvl_wr));
        check_field("level_value", 24'(want.lvl_val), 24'(got.lvl_val));
        check_field("color_write", 24'(want.rgb_wr), 24'(got.rgb_wr));
        check_field("color_value", want.rgb_val, got.rgb_val);
        check_field("notify_change", 24'(want.notify), 24'(got.notify));
        check_field("current_level", 24'(want.cur), 24'(got.cur));
        check_field("lock_pulse", 24'(want.lock), 24'(got.lock));
        check_field("padding", 24'(want.pad), 24'(got.pad));
      end
      if (got.rgb_wr) rgb_writes_seen++;
      if (got.lock) lock_pulses_seen++;
      results_seen++;
    end
  end

  // stimulus
  initial begin
    step_row_t   rw;
    logic [3:0]  fn;
    rgb_t        val;
    int          k;
    int          ph;
    int          done;
    int          pick;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed script
    for (k = 0; k < N_DIRECTED; k++) begin
      rw = directed_row(k);
      if (rw.mode != rgb_mode) begin
        drain_results();
        write_mode(rw.mode);
      end
      send_event(rw.fn, rw.val, rw.typed, rw.want);
    end

    // random phases, each opening with a colour mode write and then init
    for (ph = 0; ph < N_PHASES; ph++) begin
      drain_results();
      write_mode((ph % 3) != 1);
      steady_run = (ph == 2);
      send_event(FN_INIT, 24'($urandom_range(0, 24'hFFFFFF)), 1'b0, '0);
      done = 0;
      while (done < PHASE_ITEMS) begin
        // hold back once mid-phase until the pipe is empty
        if (ph == 3 && done == 120) drain_results();
        pick = $urandom_range(0, 99);
        val = 24'($urandom_range(0, 24'hFFFFFF));
        if (pick < 10) begin
          fn = FN_REPORT;
          val = pick_level_value();
        end else if (pick < 24) begin
          fn = FN_TOGGLE;
        end else if (pick < 38) begin
          fn = FN_DOWN;
        end else if (pick < 52) begin
          fn = FN_UP;
        end else if (pick < 66) begin
          fn = FN_CYCLE;
        end else if (pick < 70) begin
          fn = FN_LOCK;
        end else if (pick < 78) begin
          fn = FN_SET_LVL;
          val = pick_level_value();
        end else if (pick < 86) begin
          fn = FN_SET_RGB;
          val = pick_rgb_value();
        end else if (pick < 90) begin
          fn = FN_INIT;
        end else begin
          fn = 4'($urandom_range(FN_NONE_LO, FN_NONE_HI));
        end
        send_event(fn, val, 1'b0, '0);
        done++;
      end
    end

    drain_results();
    steady_run = 1'b0;
    repeat (4) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0d results never arrived", pending_results.size());
      error_count++;
    end

    $display("covered %0d events across %0d colour mode writes, directed table plus random",
             events_sent, mode_writes);
    $display("compared %0d results: %0d colour writes, %0d lock pulses, %0d field errors",
             results_seen, rgb_writes_seen, lock_pulses_seen, error_count);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
